FILE: rtl/window_color_frequency_counter_macros.svh
// Assertion macros shared by the window color frequency counter RTL.
`ifndef WINDOW_COLOR_FREQUENCY_COUNTER_MACROS_SVH
`define WINDOW_COLOR_FREQUENCY_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WCF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, checked outside reset.
`define WCF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: rtl/wcf_pkg.sv
// Shared constants, types and command/status structs of the window color frequency counter.
`default_nettype none
package wcf_pkg;
    localparam int MAX_NODES  = 1024;
    localparam int MAX_COLORS = 1024;
    localparam int BLOCK_SIZE = 32;
    localparam int NPOS       = 2 * MAX_NODES;
    localparam int NBLK       = (MAX_NODES + BLOCK_SIZE - 1) / BLOCK_SIZE + 1;
    localparam int POS_W      = $clog2(NPOS);
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int COL_W      = $clog2(MAX_COLORS);
    localparam int FREQ_W     = 11;
    localparam int BLK_W      = $clog2(NBLK);
    localparam int BLK_SH     = $clog2(BLOCK_SIZE);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_LOAD   = 2'd3;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOAD, S_TOUR, S_NODE, S_FREQ, S_CALC,
        S_RD1, S_WR1, S_RD2, S_WR2, S_QRUN, S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic clr;
        logic load_wr;
        logic seen_upd;
        logic calc;
        logic ff_old;
        logic wr_ff;
        logic q_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] kind;
        logic       q_done;
        logic       out_free;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/window_color_frequency_counter.sv
// Sliding tour window keeping per-color counts and answering frequency range queries.
// After reset the block clears its seen count, color frequency, frequency population
// and block sum tables to zero and takes no item until the sweep ends; the node_count
// register can be written at any time. It works on one item at a time, each through a
// sequence of single-port memory accesses: a load writes the tour and node color
// tables, an add or remove reads tour, color, seen count and color frequency and then
// updates the old and new frequency buckets and block sums, and a query reads one
// frequency bucket at a time, where a full block of 32 frequencies is read as one block
// sum. Each item yields one result (count is 0 but for queries), held in an output
// register so the next item is accepted while it waits.
`default_nettype none
`include "window_color_frequency_counter_macros.svh"
module window_color_frequency_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [11:0] i_position,
    input  wire logic [10:0] i_node,
    input  wire logic [9:0]  i_color,
    input  wire logic [10:0] i_min_freq,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [10:0]      o_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data
);
    wcf_pkg::t_cmd w_cmd;
    wcf_pkg::t_sts w_sts;
    logic [10:0]   r_node_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 11'(wcf_pkg::MAX_NODES);
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    wcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wcf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_node_count (r_node_count),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_node       (i_node),
        .i_color      (i_color),
        .i_min_freq   (i_min_freq),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_count      (o_count)
    );

    `WCF_ASSERT_NXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready)
    `WCF_ASSERT_IMP(a_no_item_in_clear, w_cmd.clr, !o_in_ready)
    `WCF_ASSERT_NXT(a_nonquery_zero, w_cmd.out_load && (w_sts.kind != wcf_pkg::KIND_QUERY),
                    o_out_valid && (o_count == 11'd0))
endmodule
`default_nettype wire

FILE: rtl/wcf_ctrl.sv
// Controller state machine sequencing clear, load, window update and query.
`default_nettype none
module wcf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wcf_pkg::t_sts      i_sts,
    output wcf_pkg::t_cmd      o_cmd
);
    wcf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcf_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wcf_pkg::S_CLR:  if (i_sts.clr_last) n_state = wcf_pkg::S_IDLE;
            wcf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = wcf_pkg::S_TOUR;
            end
            wcf_pkg::S_TOUR: begin
                // decode the captured kind
                unique case (i_sts.kind)
                    wcf_pkg::KIND_QUERY: n_state = wcf_pkg::S_QRUN;
                    wcf_pkg::KIND_LOAD:  n_state = wcf_pkg::S_LOAD;
                    default:             n_state = wcf_pkg::S_NODE;
                endcase
            end
            wcf_pkg::S_LOAD: n_state = wcf_pkg::S_DONE;
            wcf_pkg::S_NODE: n_state = wcf_pkg::S_FREQ;
            wcf_pkg::S_FREQ: n_state = wcf_pkg::S_CALC;
            wcf_pkg::S_CALC: n_state = wcf_pkg::S_RD1;
            wcf_pkg::S_RD1:  n_state = wcf_pkg::S_WR1;
            wcf_pkg::S_WR1:  n_state = wcf_pkg::S_RD2;
            wcf_pkg::S_RD2:  n_state = wcf_pkg::S_WR2;
            wcf_pkg::S_WR2:  n_state = wcf_pkg::S_DONE;
            wcf_pkg::S_QRUN: if (i_sts.q_done) n_state = wcf_pkg::S_DONE;
            wcf_pkg::S_DONE: if (i_sts.out_free) n_state = wcf_pkg::S_IDLE;
            default:         n_state = wcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            wcf_pkg::S_CLR:  o_cmd.clr = 1'b1;
            wcf_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            wcf_pkg::S_LOAD: o_cmd.load_wr = 1'b1;
            wcf_pkg::S_FREQ: o_cmd.seen_upd = 1'b1;
            wcf_pkg::S_CALC: o_cmd.calc = 1'b1;
            wcf_pkg::S_WR1:  o_cmd.wr_ff = 1'b1;
            wcf_pkg::S_RD2:  o_cmd.ff_old = 1'b1;
            wcf_pkg::S_WR2: begin
                o_cmd.ff_old = 1'b1;
                o_cmd.wr_ff  = 1'b1;
            end
            wcf_pkg::S_QRUN: o_cmd.q_run = 1'b1;
            wcf_pkg::S_DONE: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/wcf_dp.sv
// Datapath: tables, frequency counts, block sums, query accumulator and result register.
`default_nettype none
module wcf_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wcf_pkg::t_cmd                     i_cmd,
    output wcf_pkg::t_sts                     o_sts,
    input  wire logic [10:0]                  i_node_count,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [11:0]                  i_position,
    input  wire logic [10:0]                  i_node,
    input  wire logic [9:0]                   i_color,
    input  wire logic [10:0]                  i_min_freq,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [10:0]                       o_count
);
    localparam int FW = wcf_pkg::FREQ_W;
    localparam int BLK_TOP = FW;

    logic [wcf_pkg::NODE_W-1:0] m_tour  [wcf_pkg::NPOS];
    logic [wcf_pkg::COL_W-1:0]  m_color [wcf_pkg::MAX_NODES];
    logic [1:0]                 m_seen  [wcf_pkg::MAX_NODES];
    logic [FW-1:0]              m_cf    [wcf_pkg::MAX_COLORS];
    logic [FW-1:0]              m_fof   [wcf_pkg::MAX_NODES];
    logic [FW-1:0]              m_bs    [wcf_pkg::NBLK];

    logic [1:0]                 r_kind;
    logic [wcf_pkg::POS_W-1:0]  r_pos;
    logic [wcf_pkg::NODE_W-1:0] r_node;
    logic [wcf_pkg::COL_W-1:0]  r_color;
    logic [FW-1:0]              r_hi;
    logic [FW:0]                r_i;
    logic [FW-1:0]              r_sum;
    logic                       r_pend, r_psrc;
    logic [wcf_pkg::NODE_W-1:0] r_tour_q;
    logic [wcf_pkg::COL_W-1:0]  r_color_q;
    logic [1:0]                 r_seen_q;
    logic [FW-1:0]              r_cf_q, r_fof_q, r_bs_q;
    logic                       r_hit, r_go;
    logic [FW-1:0]              r_f_old, r_f_new;
    logic [wcf_pkg::NODE_W-1:0] r_clr;
    logic                       r_out_valid;
    logic [FW-1:0]              r_out_count;

    logic                       w_add;
    logic [1:0]                 w_seen_new;
    logic                       w_seen_ok, w_hit;
    logic                       w_go;
    logic [FW-1:0]              w_f_new;
    logic [FW-1:0]              w_lo, w_hi;
    logic [FW-1:0]              w_t;
    logic [FW:0]                w_t_ext;
    logic [wcf_pkg::NODE_W-1:0] w_idx, w_qidx, w_fof_addr;
    logic [BLK_TOP:0]           w_blk_sum, w_qblk_sum;
    logic [wcf_pkg::BLK_W-1:0]  w_blk, w_qblk, w_bs_addr;
    logic                       w_issue, w_whole;
    logic [FW:0]                w_qend;

    assign w_add      = (r_kind == wcf_pkg::KIND_ADD);
    assign w_seen_new = w_add ? r_seen_q + 2'd1 : r_seen_q - 2'd1;
    assign w_seen_ok  = w_add ? (r_seen_q != 2'd3) : (r_seen_q != 2'd0);
    assign w_hit      = w_seen_ok && (w_add ? (w_seen_new == 2'd2) : (w_seen_new == 2'd1));
    assign w_go       = r_hit && (w_add ? (r_cf_q < FW'(wcf_pkg::MAX_NODES))
                                        : (r_cf_q != '0));
    assign w_f_new    = w_add ? r_cf_q + FW'(1) : r_cf_q - FW'(1);

    assign w_lo = (i_min_freq == '0) ? FW'(1) : i_min_freq;
    assign w_hi = (i_node_count > FW'(wcf_pkg::MAX_NODES)) ? FW'(wcf_pkg::MAX_NODES)
                                                           : i_node_count;

    // frequency bucket touched by the current update step
    assign w_t        = i_cmd.ff_old ? r_f_old : r_f_new;
    assign w_t_ext    = {1'b0, w_t};
    assign w_idx      = wcf_pkg::NODE_W'(w_t - FW'(1));
    assign w_blk_sum  = w_t_ext + (FW+1)'(wcf_pkg::BLOCK_SIZE - 1);
    assign w_blk      = w_blk_sum[wcf_pkg::BLK_SH +: wcf_pkg::BLK_W];

    assign w_qidx     = wcf_pkg::NODE_W'(r_i - (FW+1)'(1));
    assign w_qblk_sum = r_i + (FW+1)'(wcf_pkg::BLOCK_SIZE - 1);
    assign w_qblk     = w_qblk_sum[wcf_pkg::BLK_SH +: wcf_pkg::BLK_W];
    assign w_qend     = r_i + (FW+1)'(wcf_pkg::BLOCK_SIZE - 1);
    assign w_issue    = i_cmd.q_run && (r_i <= {1'b0, r_hi});
    // take a whole block sum when the block starts here and ends inside the range
    assign w_whole    = (w_qidx[wcf_pkg::BLK_SH-1:0] == '0) && (w_qend <= {1'b0, r_hi});

    assign w_fof_addr = i_cmd.q_run ? w_qidx : w_idx;
    assign w_bs_addr  = i_cmd.q_run ? w_qblk : w_blk;

    // item capture and query walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_pos   <= i_position[wcf_pkg::POS_W-1:0];
            r_node  <= i_node[wcf_pkg::NODE_W-1:0];
            r_color <= i_color;
            r_i     <= {1'b0, w_lo};
            r_hi    <= w_hi;
            r_sum   <= '0;
            r_pend  <= 1'b0;
        end else if (i_cmd.q_run) begin
            if (r_pend) begin
                r_sum <= r_sum + (r_psrc ? r_bs_q : r_fof_q);
            end
            r_pend <= w_issue;
            r_psrc <= w_whole;
            if (w_issue) begin
                r_i <= r_i + (w_whole ? (FW+1)'(wcf_pkg::BLOCK_SIZE) : (FW+1)'(1));
            end
        end
    end

    // tour table and node colors
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            m_tour[r_pos]   <= r_node;
            m_color[r_node] <= r_color;
        end
        r_tour_q  <= m_tour[r_pos];
        r_color_q <= m_color[r_tour_q];
    end

    // seen counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            m_seen[r_clr] <= 2'd0;
        end else if (i_cmd.seen_upd && w_seen_ok) begin
            m_seen[r_tour_q] <= w_seen_new;
        end
        r_seen_q <= m_seen[r_tour_q];
        if (i_cmd.seen_upd) begin
            r_hit <= w_hit;
        end
    end

    // color frequencies
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            m_cf[r_clr] <= '0;
        end else if (i_cmd.calc && w_go) begin
            m_cf[r_color_q] <= w_f_new;
        end
        r_cf_q <= m_cf[r_color_q];
        if (i_cmd.calc) begin
            r_go    <= w_go;
            r_f_old <= r_cf_q;
            r_f_new <= w_f_new;
        end
    end

    // frequency populations and block sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            m_fof[r_clr] <= '0;
        end else if (i_cmd.wr_ff && r_go && (w_t != '0)) begin
            m_fof[w_idx] <= i_cmd.ff_old ? r_fof_q - FW'(1) : r_fof_q + FW'(1);
        end
        r_fof_q <= m_fof[w_fof_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if ({1'b0, r_clr} < (wcf_pkg::NODE_W+1)'(wcf_pkg::NBLK)) begin
                m_bs[r_clr[wcf_pkg::BLK_W-1:0]] <= '0;
            end
        end else if (i_cmd.wr_ff && r_go && (w_t != '0)) begin
            m_bs[w_blk] <= i_cmd.ff_old ? r_bs_q - FW'(1) : r_bs_q + FW'(1);
        end
        r_bs_q <= m_bs[w_bs_addr];
    end

    // clear pointer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + wcf_pkg::NODE_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= (r_kind == wcf_pkg::KIND_QUERY) ? r_sum : '0;
        end
    end

    assign o_sts.clr_last = &r_clr;
    assign o_sts.kind     = r_kind;
    assign o_sts.q_done   = (r_i > {1'b0, r_hi}) && !r_pend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_count        = r_out_count;
endmodule
`default_nettype wire
